### sv/qes_pkg.sv
package qes_pkg;

    localparam int OUT_W       = 32;
    localparam int SCALE_W     = 16;
    localparam int SCALE_IDX_W = 4;
    localparam int QUO_BITS    = OUT_W + 1;
    localparam int STEP_W      = 6;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    localparam logic [SCALE_W-1:0] SCALE_RESET   = 16'd14960;
    localparam logic [DATA_W-1:0]  TIMEOUT_RESET = 32'd50000;
    localparam logic [OUT_W-1:0]   SPEED_MAX     = 32'h7FFF_FFFF;
    localparam logic [OUT_W-1:0]   SPEED_MIN     = 32'h8000_0000;

    typedef enum logic [1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_LOAD   = 2'd1,
        MODE_QUERY  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        REG_INVERT  = 2'd0,
        REG_CLAMP   = 2'd1,
        REG_SCALE   = 2'd2,
        REG_TIMEOUT = 2'd3
    } t_reg_idx;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef enum logic [2:0] {
        SP_IDLE,
        SP_ABS,
        SP_MUL,
        SP_CHECK,
        SP_DIV,
        SP_SAT
    } t_spd_state;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_OUT
    } t_top_state;

    typedef struct packed {
        logic               invert_direction;
        logic               clamp_nonnegative;
        logic [SCALE_W-1:0] speed_scale;
        logic [DATA_W-1:0]  stale_timeout_us;
    } t_cfg;

    typedef struct packed {
        logic             done;
        logic [OUT_W-1:0] speed;
        logic             sat;
    } t_spd_res;

endpackage

### sv/qes_ifs.sv
interface qes_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic               a_level;
    logic               b_level;
    logic [31:0]        timestamp_us;
    logic signed [31:0] load_value;

    modport source (
        output valid, mode, a_level, b_level, timestamp_us, load_value,
        input  ready
    );
    modport sink (
        input  valid, mode, a_level, b_level, timestamp_us, load_value,
        output ready
    );
endinterface

interface qes_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] position;
    logic signed [31:0] speed;
    logic               speed_saturated;

    modport source (
        output valid, position, speed, speed_saturated,
        input  ready
    );
    modport sink (
        input  valid, position, speed, speed_saturated,
        output ready
    );
endinterface

### sv/qes_cfg_regs.sv
module qes_cfg_regs
    import qes_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_write;

    assign w_idx   = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_write = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.invert_direction  <= 1'b0;
            r_cfg.clamp_nonnegative <= 1'b0;
            r_cfg.speed_scale       <= SCALE_RESET;
            r_cfg.stale_timeout_us  <= TIMEOUT_RESET;
        end else if (w_write) begin
            unique case (w_idx)
                REG_INVERT:  r_cfg.invert_direction  <= pwdata[0];
                REG_CLAMP:   r_cfg.clamp_nonnegative <= pwdata[0];
                REG_SCALE:   r_cfg.speed_scale       <= pwdata[SCALE_W-1:0];
                REG_TIMEOUT: r_cfg.stale_timeout_us  <= pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_INVERT:  prdata = {{(DATA_W-1){1'b0}}, r_cfg.invert_direction};
            REG_CLAMP:   prdata = {{(DATA_W-1){1'b0}}, r_cfg.clamp_nonnegative};
            REG_SCALE:   prdata = {{(DATA_W-SCALE_W){1'b0}}, r_cfg.speed_scale};
            REG_TIMEOUT: prdata = r_cfg.stale_timeout_us;
        endcase
    end

endmodule

### sv/qes_alu.sv
module qes_alu
    import qes_pkg::*;
#(
    parameter int W = 64
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  t_alu_op      i_op,
    output logic [W-1:0] o_sum,
    output logic         o_carry
);

    logic [W-1:0] w_b;
    logic         w_cin;

    assign w_cin = (i_op == ALU_SUB);
    assign w_b   = w_cin ? ~i_b : i_b;
    assign {o_carry, o_sum} = {1'b0, i_a} + {1'b0, w_b} + {{W{1'b0}}, w_cin};

endmodule

### sv/qes_speed_unit.sv
module qes_speed_unit
    import qes_pkg::*;
#(
    parameter int COUNT_WIDTH = 32,
    parameter int TIME_WIDTH  = 32,
    parameter int FRAC_BITS   = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [COUNT_WIDTH-1:0] i_count_now,
    input  logic [COUNT_WIDTH-1:0] i_count_before,
    input  logic [TIME_WIDTH-1:0]  i_dt,
    input  logic [SCALE_W-1:0]     i_scale,
    output t_spd_res               o_res
);

    localparam int PW = COUNT_WIDTH + SCALE_W + FRAC_BITS;
    localparam int DW = TIME_WIDTH + QUO_BITS;
    localparam int AW = ((PW > DW) ? PW : DW) + 1;

    t_spd_state r_state, n_state;
    logic                   r_done, n_done;
    logic [OUT_W-1:0]       r_speed, n_speed;
    logic                   r_sat, n_sat;
    logic [AW-1:0]          r_acc, n_acc;
    logic [AW-1:0]          r_div, n_div;
    logic [COUNT_WIDTH-1:0] r_mag, n_mag;
    logic                   r_neg, n_neg;
    logic [TIME_WIDTH-1:0]  r_dt, n_dt;
    logic [SCALE_W-1:0]     r_scale, n_scale;
    logic [STEP_W-1:0]      r_step, n_step;
    logic [QUO_BITS-1:0]    r_quo, n_quo;

    logic [AW-1:0] w_alu_a, w_alu_b, w_sum;
    logic          w_carry;
    t_alu_op       w_op;

    qes_alu #(.W(AW)) u_alu (
        .i_a     (w_alu_a),
        .i_b     (w_alu_b),
        .i_op    (w_op),
        .o_sum   (w_sum),
        .o_carry (w_carry)
    );

    assign o_res.done  = r_done;
    assign o_res.speed = r_speed;
    assign o_res.sat   = r_sat;

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        n_speed = r_speed;
        n_sat   = r_sat;
        n_acc   = r_acc;
        n_div   = r_div;
        n_mag   = r_mag;
        n_neg   = r_neg;
        n_dt    = r_dt;
        n_scale = r_scale;
        n_step  = r_step;
        n_quo   = r_quo;
        w_alu_a = '0;
        w_alu_b = '0;
        w_op    = ALU_ADD;
        unique case (r_state)
            SP_IDLE: begin
                w_alu_a = AW'(signed'(i_count_now));
                w_alu_b = AW'(signed'(i_count_before));
                w_op    = ALU_SUB;
                if (i_start) begin
                    n_acc   = w_sum;
                    n_dt    = i_dt;
                    n_scale = i_scale;
                    n_state = SP_ABS;
                end
            end
            SP_ABS: begin
                w_alu_a = '0;
                w_alu_b = r_acc;
                w_op    = ALU_SUB;
                n_neg   = r_acc[AW-1];
                n_mag   = r_acc[AW-1] ? w_sum[COUNT_WIDTH-1:0] : r_acc[COUNT_WIDTH-1:0];
                n_acc   = '0;
                n_div   = AW'(r_dt) << QUO_BITS;
                n_step  = STEP_W'(SCALE_W - 1);
                n_state = SP_MUL;
            end
            SP_MUL: begin
                w_alu_a = r_acc << 1;
                w_alu_b = r_scale[r_step[SCALE_IDX_W-1:0]] ? AW'(r_mag) : '0;
                w_op    = ALU_ADD;
                if (r_step == '0) begin
                    n_acc   = w_sum << FRAC_BITS;
                    n_state = SP_CHECK;
                end else begin
                    n_acc  = w_sum;
                    n_step = r_step - 1'b1;
                end
            end
            SP_CHECK: begin
                w_alu_a = r_acc;
                w_alu_b = r_div;
                w_op    = ALU_SUB;
                if (r_dt == '0) begin
                    n_sat   = 1'b1;
                    n_speed = (r_acc == '0) ? '0 : (r_neg ? SPEED_MIN : SPEED_MAX);
                    n_done  = 1'b1;
                    n_state = SP_IDLE;
                end else if (w_carry) begin
                    n_sat   = 1'b1;
                    n_speed = r_neg ? SPEED_MIN : SPEED_MAX;
                    n_done  = 1'b1;
                    n_state = SP_IDLE;
                end else begin
                    n_div   = r_div >> 1;
                    n_step  = STEP_W'(QUO_BITS - 1);
                    n_quo   = '0;
                    n_state = SP_DIV;
                end
            end
            SP_DIV: begin
                w_alu_a = r_acc;
                w_alu_b = r_div;
                w_op    = ALU_SUB;
                if (w_carry) begin
                    n_acc = w_sum;
                end
                n_quo = {r_quo[QUO_BITS-2:0], w_carry};
                n_div = r_div >> 1;
                if (r_step == '0) begin
                    n_state = SP_SAT;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            SP_SAT: begin
                if (!r_neg) begin
                    if (r_quo[QUO_BITS-1] | r_quo[OUT_W-1]) begin
                        n_speed = SPEED_MAX;
                        n_sat   = 1'b1;
                    end else begin
                        n_speed = r_quo[OUT_W-1:0];
                        n_sat   = 1'b0;
                    end
                end else begin
                    if (r_quo[QUO_BITS-1] | (r_quo[OUT_W-1] & (|r_quo[OUT_W-2:0]))) begin
                        n_speed = SPEED_MIN;
                        n_sat   = 1'b1;
                    end else begin
                        n_speed = {OUT_W{1'b0}} - r_quo[OUT_W-1:0];
                        n_sat   = 1'b0;
                    end
                end
                n_done  = 1'b1;
                n_state = SP_IDLE;
            end
            default: begin
                n_state = SP_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SP_IDLE;
            r_done  <= 1'b0;
            r_speed <= '0;
            r_sat   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_speed <= n_speed;
            r_sat   <= n_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc   <= n_acc;
        r_div   <= n_div;
        r_mag   <= n_mag;
        r_neg   <= n_neg;
        r_dt    <= n_dt;
        r_scale <= n_scale;
        r_step  <= n_step;
        r_quo   <= n_quo;
    end

    a_done_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_state == SP_IDLE)
        else $error("speed done raised outside idle");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == SP_DIV |-> r_div != '0)
        else $error("divide step with zero divisor");

    a_sign_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && !r_sat && r_speed != '0) |-> r_speed[OUT_W-1] == r_neg)
        else $error("unsaturated speed sign differs from count change");

endmodule

### sv/quadrature_encoder_speed_top.sv
// Channel   Dir  Handshake       Payload
// i_item    in   valid/ready     mode, a_level, b_level, timestamp_us, load_value
// o_result  out  valid/ready     position, speed, speed_saturated
// apb       in   psel/penable    paddr, pwdata, prdata (4 registers at 4*i)
//
// A rising A edge runs the speed unit from acceptance to result: 16 shift-add
// multiply steps and up to 33 restoring divide steps run on one shared adder.
// Any other request skips the speed unit. One request is in flight at a time.
// A finished result waits in the output register while the next request enters.
// Reset is synchronous, active low, and needs no clearing pass.
module quadrature_encoder_speed_top
    import qes_pkg::*;
#(
    parameter int COUNT_WIDTH = 32,
    parameter int TIME_WIDTH  = 32,
    parameter int FRAC_BITS   = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    qes_in_if.sink            i_item,
    qes_out_if.source         o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int CMPW = (TIME_WIDTH > DATA_W) ? TIME_WIDTH : DATA_W;

    t_cfg       w_cfg;
    t_spd_res   w_spd;
    t_top_state r_state, n_state;

    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic [COUNT_WIDTH-1:0] r_count_last, n_count_last;
    logic [TIME_WIDTH-1:0]  r_time_last, n_time_last;
    logic                   r_prev_a, n_prev_a;
    logic [TIME_WIDTH-1:0]  r_dt, n_dt;
    logic                   r_stale, n_stale;
    logic                   r_out_valid, n_out_valid;
    logic [OUT_W-1:0]       r_out_pos, n_out_pos;
    logic [OUT_W-1:0]       r_out_speed, n_out_speed;
    logic                   r_out_sat, n_out_sat;

    logic                   w_accept;
    logic                   w_edge;
    logic                   w_up;
    logic                   w_start;
    logic                   w_stale;
    logic                   w_slot_free;
    logic [TIME_WIDTH-1:0]  w_ts;
    logic [TIME_WIDTH-1:0]  w_age;
    logic [COUNT_WIDTH-1:0] w_step;

    qes_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    qes_speed_unit #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .TIME_WIDTH  (TIME_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_speed (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (w_start),
        .i_count_now    (r_count),
        .i_count_before (r_count_last),
        .i_dt           (r_dt),
        .i_scale        (w_cfg.speed_scale),
        .o_res          (w_spd)
    );

    assign i_item.ready             = (r_state == ST_IDLE);
    assign o_result.valid           = r_out_valid;
    assign o_result.position        = r_out_pos;
    assign o_result.speed           = r_out_speed;
    assign o_result.speed_saturated = r_out_sat;

    assign w_accept    = i_item.valid & i_item.ready;
    assign w_ts        = TIME_WIDTH'(i_item.timestamp_us);
    assign w_age       = w_ts - r_time_last;
    assign w_stale     = CMPW'(w_age) > CMPW'(w_cfg.stale_timeout_us);
    assign w_edge      = (i_item.mode == MODE_SAMPLE) && (i_item.a_level != r_prev_a)
                         && i_item.a_level;
    assign w_up        = (i_item.a_level == i_item.b_level) ? w_cfg.invert_direction
                                                            : !w_cfg.invert_direction;
    assign w_step      = w_up ? (r_count + 1'b1) : (r_count - 1'b1);
    assign w_slot_free = !r_out_valid || o_result.ready;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_count_last = r_count_last;
        n_time_last  = r_time_last;
        n_prev_a     = r_prev_a;
        n_dt         = r_dt;
        n_stale      = r_stale;
        n_out_valid  = r_out_valid;
        n_out_pos    = r_out_pos;
        n_out_speed  = r_out_speed;
        n_out_sat    = r_out_sat;
        w_start      = 1'b0;
        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_stale = w_stale;
                    n_state = ST_OUT;
                    unique case (i_item.mode)
                        MODE_SAMPLE: begin
                            if (i_item.a_level != r_prev_a) begin
                                n_prev_a = i_item.a_level;
                                if (i_item.a_level) begin
                                    n_count = (w_cfg.clamp_nonnegative && w_step[COUNT_WIDTH-1])
                                              ? '0 : w_step;
                                    n_time_last = w_ts;
                                    n_dt        = w_age;
                                    n_stale     = 1'b0;
                                    n_state     = ST_START;
                                end
                            end
                        end
                        MODE_LOAD: begin
                            n_count = COUNT_WIDTH'(i_item.load_value);
                        end
                        MODE_QUERY: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_START: begin
                w_start      = 1'b1;
                n_count_last = r_count;
                n_state      = ST_WAIT;
            end
            ST_WAIT: begin
                if (w_spd.done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_pos   = OUT_W'(r_count);
                    n_out_speed = r_stale ? '0 : w_spd.speed;
                    n_out_sat   = r_stale ? 1'b0 : w_spd.sat;
                    n_state     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= '0;
            r_count_last <= '0;
            r_time_last  <= '0;
            r_prev_a     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_count_last <= n_count_last;
            r_time_last  <= n_time_last;
            r_prev_a     <= n_prev_a;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dt        <= n_dt;
        r_stale     <= n_stale;
        r_out_pos   <= n_out_pos;
        r_out_speed <= n_out_speed;
        r_out_sat   <= n_out_sat;
    end

    a_edge_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_edge) |=> r_state == ST_START)
        else $error("rising A edge did not start speed update");

    a_clamp_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_edge && w_cfg.clamp_nonnegative) |=> !r_count[COUNT_WIDTH-1])
        else $error("clamped count went negative");

    a_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_spd.done |-> r_state == ST_WAIT)
        else $error("speed result arrived while not waiting");

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import qes_pkg::*;

    localparam int          FRAC_BITS   = 8;
    localparam int          CYCLE_LIMIT = 1_000_000;
    localparam int          SETTLE      = 60;
    localparam int          PHASE_ITEMS = 620;
    localparam int          PAUSE_EVERY = 150;
    localparam logic [1:0]  MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [31:0] position;
        logic signed [31:0] speed;
        logic               sat;
    } t_reading;

    typedef struct packed {
        logic [1:0]  mode;
        logic        a;
        logic        b;
        logic [31:0] stamp;
        logic [31:0] load;
        logic        checked;
        t_reading    want;
    } t_request;

    typedef struct packed {
        logic        is_setting;
        t_reg_idx    idx;
        logic [31:0] value;
        t_request    req;
    } t_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    qes_in_if  item_if ();
    qes_out_if result_if ();

    quadrature_encoder_speed_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    logic               cfg_invert;
    logic               cfg_clamp;
    logic [SCALE_W-1:0] cfg_scale;
    logic [31:0]        cfg_timeout;

    logic signed [31:0] enc_position;
    logic signed [31:0] edge_position;
    logic [31:0]        edge_time;
    logic               last_a;
    logic [31:0]        held_speed;
    logic               held_sat;

    t_request    pending_samples[$];
    t_reading    expected_readings[$];
    t_row        directed_rows[$];
    int unsigned mismatch_count;
    int unsigned cycle_count;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    logic [1:0]  motion_phase;
    logic        motion_dir;
    logic [31:0] motion_time;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("FAIL quadrature_encoder_speed_top");
        $finish;
    end

    function automatic t_reading advance_encoder(t_request r);
        t_reading    rd;
        longint      now_pos;
        longint      was_pos;
        logic [63:0] delta;
        logic [63:0] product;
        logic [63:0] quotient;
        logic [31:0] elapsed;
        logic        moving_back;
        logic        step_up;
        if (r.mode == MODE_SAMPLE) begin
            if (r.a != last_a) begin
                last_a = r.a;
                if (r.a) begin
                    step_up = (r.a == r.b) ? cfg_invert : !cfg_invert;
                    enc_position = step_up ? enc_position + 32'sd1 : enc_position - 32'sd1;
                    if (cfg_clamp && enc_position < 0) begin
                        enc_position = '0;
                    end
                    now_pos     = enc_position;
                    was_pos     = edge_position;
                    moving_back = now_pos < was_pos;
                    delta       = moving_back ? 64'(was_pos - now_pos) : 64'(now_pos - was_pos);
                    product     = delta * 64'({cfg_scale, {FRAC_BITS{1'b0}}});
                    elapsed     = r.stamp - edge_time;
                    if (elapsed == 0) begin
                        held_sat   = 1'b1;
                        held_speed = (product == 0) ? '0 : (moving_back ? SPEED_MIN : SPEED_MAX);
                    end else begin
                        quotient = product / 64'(elapsed);
                        if (!moving_back) begin
                            held_sat   = quotient > 64'(SPEED_MAX);
                            held_speed = held_sat ? SPEED_MAX : quotient[31:0];
                        end else begin
                            held_sat   = quotient > 64'(SPEED_MIN);
                            held_speed = held_sat ? SPEED_MIN : -quotient[31:0];
                        end
                    end
                    edge_position = enc_position;
                    edge_time     = r.stamp;
                end
            end
        end else if (r.mode == MODE_LOAD) begin
            enc_position = r.load;
        end
        elapsed     = r.stamp - edge_time;
        rd.position = enc_position;
        if (elapsed > cfg_timeout) begin
            rd.speed = '0;
            rd.sat   = 1'b0;
        end else begin
            rd.speed = held_speed;
            rd.sat   = held_sat;
        end
        return rd;
    endfunction

    function automatic t_request make_request(logic [1:0] mode, logic a, logic b,
                                              logic [31:0] stamp, logic [31:0] load);
        t_request r;
        r         = '0;
        r.mode    = mode;
        r.a       = a;
        r.b       = b;
        r.stamp   = stamp;
        r.load    = load;
        return r;
    endfunction

    function automatic void add_item(logic [1:0] mode, logic a, logic b,
                                     logic [31:0] stamp, logic [31:0] load);
        t_row row;
        row     = '0;
        row.req = make_request(mode, a, b, stamp, load);
        directed_rows.push_back(row);
    endfunction

    function automatic void add_checked(logic [1:0] mode, logic a, logic b,
                                        logic [31:0] stamp, logic [31:0] load,
                                        logic [31:0] pos, logic [31:0] spd, logic sat);
        t_row row;
        row                  = '0;
        row.req              = make_request(mode, a, b, stamp, load);
        row.req.checked      = 1'b1;
        row.req.want.position = pos;
        row.req.want.speed    = spd;
        row.req.want.sat      = sat;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_setting(t_reg_idx idx, logic [31:0] value);
        t_row row;
        row            = '0;
        row.is_setting = 1'b1;
        row.idx        = idx;
        row.value      = value;
        directed_rows.push_back(row);
    endfunction

    task automatic wait_idle();
        while (pending_samples.size() != 0 || item_if.valid || expected_readings.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_setting(t_reg_idx idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_INVERT:  cfg_invert  = value[0];
            REG_CLAMP:   cfg_clamp   = value[0];
            REG_SCALE:   cfg_scale   = value[SCALE_W-1:0];
            REG_TIMEOUT: cfg_timeout = value;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic queue_request(t_request r);
        while (pending_samples.size() >= 2) @(posedge i_clk);
        pending_samples.push_back(r);
    endtask

    task automatic queue_random_request();
        t_request    r;
        int unsigned pick;
        int unsigned span;
        logic [31:0] gap;
        pick = $urandom_range(19);
        if (pick < 3) begin
            gap = 0;
        end else if (pick < 14) begin
            gap = $urandom_range(200, 1);
        end else if (pick < 17) begin
            gap = $urandom_range(5000, 201);
        end else if (pick < 19) begin
            gap = $urandom_range(120000, 5001);
        end else begin
            gap = $urandom;
        end
        motion_time = motion_time + gap;
        r = make_request(MODE_SAMPLE, 1'b0, 1'b0, motion_time, $urandom);
        pick = $urandom_range(99);
        if (pick < 75) begin
            if ($urandom_range(9) == 0) begin
                motion_dir = !motion_dir;
            end
            motion_phase = motion_dir ? motion_phase + 2'd1 : motion_phase - 2'd1;
            r.a = motion_phase[0] ^ motion_phase[1];
            r.b = motion_phase[1];
        end else if (pick < 83) begin
            r.mode = ($urandom_range(3) == 0) ? MODE_UNUSED : MODE_QUERY;
            r.a    = 1'($urandom_range(1));
            r.b    = 1'($urandom_range(1));
        end else if (pick < 90) begin
            r.mode = MODE_LOAD;
            span   = $urandom_range(99);
            if (span < 60) begin
                r.load = $urandom_range(2000) - 1000;
            end else if (span < 85) begin
                r.load = $urandom;
            end else begin
                case ($urandom_range(3))
                    0:       r.load = 32'h7FFF_FFFF;
                    1:       r.load = 32'h8000_0000;
                    2:       r.load = 32'hFFFF_FFFF;
                    default: r.load = 32'h0000_0000;
                endcase
            end
        end else begin
            r.a = 1'($urandom_range(1));
            r.b = 1'($urandom_range(1));
            if ($urandom_range(1)) begin
                r.stamp     = $urandom;
                motion_time = r.stamp;
            end
        end
        queue_request(r);
    endtask

    // drive requests; predict each one as it is taken
    initial begin
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (item_if.valid && item_if.ready) begin
                t_request taken;
                t_reading predicted;
                taken     = pending_samples.pop_front();
                predicted = advance_encoder(taken);
                expected_readings.push_back(taken.checked ? taken.want : predicted);
            end
            if (!(item_if.valid && !item_if.ready)) begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    item_if.valid        <= 1'b1;
                    item_if.mode         <= pending_samples[0].mode;
                    item_if.a_level      <= pending_samples[0].a;
                    item_if.b_level      <= pending_samples[0].b;
                    item_if.timestamp_us <= pending_samples[0].stamp;
                    item_if.load_value   <= pending_samples[0].load;
                end else begin
                    item_if.valid <= 1'b0;
                end
            end
        end
    end

    initial begin
        t_reading got;
        t_reading want;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (result_if.valid && result_if.ready) begin
                got.position = result_if.position;
                got.speed    = result_if.speed;
                got.sat      = result_if.speed_saturated;
                if (expected_readings.size() == 0) begin
                    $display("%0t unexpected result: position %0d speed %0d saturated %0b",
                             $time, got.position, got.speed, got.sat);
                    mismatch_count++;
                end else begin
                    want = expected_readings.pop_front();
                    if (got.position !== want.position) begin
                        $display("%0t position: expected %0d, got %0d",
                                 $time, want.position, got.position);
                        mismatch_count++;
                    end
                    if (got.speed !== want.speed) begin
                        $display("%0t speed: expected %0d, got %0d",
                                 $time, want.speed, got.speed);
                        mismatch_count++;
                    end
                    if (got.sat !== want.sat) begin
                        $display("%0t speed_saturated: expected %0b, got %0b",
                                 $time, want.sat, got.sat);
                        mismatch_count++;
                    end
                end
            end
            result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        i_rst_n              = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        item_if.valid        = 1'b0;
        item_if.mode         = MODE_SAMPLE;
        item_if.a_level      = 1'b0;
        item_if.b_level      = 1'b0;
        item_if.timestamp_us = '0;
        item_if.load_value   = '0;
        result_if.ready      = 1'b0;
        mismatch_count       = 0;
        cycle_count          = 0;
        send_idle_pct        = 30;
        recv_idle_pct        = 73;
        cfg_invert           = 1'b0;
        cfg_clamp            = 1'b0;
        cfg_scale            = SCALE_RESET;
        cfg_timeout          = TIMEOUT_RESET;
        enc_position         = '0;
        edge_position        = '0;
        edge_time            = '0;
        last_a               = 1'b0;
        held_speed           = '0;
        held_sat             = 1'b0;
        motion_phase         = 2'd0;
        motion_dir           = 1'b1;

        add_checked(MODE_QUERY,  0, 0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
        add_checked(MODE_SAMPLE, 1, 0, 32'd0, 32'hFFFF_FFFF, 32'd1, SPEED_MAX, 1'b1);
        add_item(MODE_SAMPLE, 0, 0, 32'd100, 32'd0);
        add_item(MODE_SAMPLE, 1, 1, 32'd1000, 32'd0);
        add_item(MODE_SAMPLE, 1, 1, 32'd1010, 32'd0);
        add_item(MODE_SAMPLE, 0, 1, 32'd1020, 32'd0);
        add_item(MODE_SAMPLE, 1, 0, 32'd1100, 32'd0);
        add_checked(MODE_QUERY,  1, 1, 32'd60000, 32'hFFFF_FFFF, 32'd1, 32'd0, 1'b0);
        add_item(MODE_LOAD,   0, 0, 32'd1200, 32'h7FFF_FFFF);
        add_item(MODE_SAMPLE, 0, 0, 32'd1300, 32'd0);
        add_checked(MODE_SAMPLE, 1, 0, 32'd1301, 32'd0, 32'h8000_0000, SPEED_MIN, 1'b1);
        add_checked(MODE_UNUSED, 1, 1, 32'd1301, 32'h5A5A_A5A5, 32'h8000_0000, SPEED_MIN, 1'b1);
        add_item(MODE_LOAD,   0, 0, 32'd1400, 32'h8000_0000);
        add_setting(REG_INVERT, 32'd1);
        add_setting(REG_CLAMP,  32'd1);
        add_item(MODE_SAMPLE, 0, 0, 32'd1500, 32'd0);
        add_checked(MODE_SAMPLE, 1, 0, 32'd1600, 32'd0, 32'h7FFF_FFFF, SPEED_MAX, 1'b1);
        add_item(MODE_LOAD,   0, 0, 32'd1700, -32'sd5);
        add_item(MODE_SAMPLE, 0, 0, 32'd1800, 32'd0);
        add_checked(MODE_SAMPLE, 1, 0, 32'd1900, 32'd0, 32'd0, SPEED_MIN, 1'b1);
        add_item(MODE_SAMPLE, 0, 1, 32'd2000, 32'd0);
        add_item(MODE_SAMPLE, 1, 1, 32'd2000, 32'd0);
        add_setting(REG_SCALE,   32'd65535);
        add_setting(REG_TIMEOUT, 32'd0);
        add_item(MODE_SAMPLE, 0, 1, 32'd2100, 32'd0);
        add_item(MODE_SAMPLE, 1, 1, 32'd2105, 32'd0);
        add_checked(MODE_QUERY,  0, 0, 32'd2106, 32'd0, 32'd2, 32'd0, 1'b0);
        add_setting(REG_TIMEOUT, 32'hFFFF_FFFF);
        add_setting(REG_SCALE,   32'd1);
        add_item(MODE_SAMPLE, 0, 1, 32'hFFFF_FF00, 32'd0);
        add_item(MODE_SAMPLE, 1, 1, 32'h0000_0040, 32'd0);
        add_item(MODE_QUERY,  1, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            if (directed_rows[k].is_setting) begin
                wait_idle();
                write_setting(directed_rows[k].idx, directed_rows[k].value);
            end else begin
                queue_request(directed_rows[k].req);
            end
        end
        motion_time = 32'h0000_1000;

        for (int phase = 0; phase < 3; phase++) begin
            wait_idle();
            case (phase)
                0: begin
                    send_idle_pct = 30;
                    recv_idle_pct = 73;
                    write_setting(REG_INVERT,  32'd0);
                    write_setting(REG_CLAMP,   32'd0);
                    write_setting(REG_SCALE,   32'(SCALE_RESET));
                    write_setting(REG_TIMEOUT, TIMEOUT_RESET);
                end
                1: begin
                    send_idle_pct = 73;
                    recv_idle_pct = 30;
                    write_setting(REG_INVERT,  32'd1);
                    write_setting(REG_CLAMP,   32'd1);
                    write_setting(REG_SCALE,   32'd65535);
                    write_setting(REG_TIMEOUT, 32'd5000);
                    motion_time = 32'hFFF0_0000;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    write_setting(REG_INVERT,  $urandom_range(1));
                    write_setting(REG_CLAMP,   32'd0);
                    write_setting(REG_SCALE,   $urandom_range(65535, 1));
                    write_setting(REG_TIMEOUT, $urandom_range(200000));
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % PAUSE_EVERY == PAUSE_EVERY - 1) begin
                    wait_idle();
                end
                queue_random_request();
            end
        end

        wait_idle();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatch_count == 0 && expected_readings.size() == 0) begin
            $display("PASS quadrature_encoder_speed_top");
        end else begin
            $display("FAIL quadrature_encoder_speed_top");
        end
        $finish;
    end

endmodule
